// ===== rtl/awbcal_pkg.sv =====
// Shared constants and types for the white-balance calibration gain calculator.
`default_nettype none
package awbcal_pkg;
   localparam int GAIN_W     = 16;
   localparam int WORD_W     = 32;
   localparam int DGAIN_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_STAGES = WORD_W;
   localparam int LATENCY    = 3 * DIV_STAGES + 4;

   localparam logic [CSR_IDX_W-1:0] CSR_GOLDEN_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOLDEN_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GOLDEN_BLUE  = 2'd2;

   localparam logic [GAIN_W-1:0] GOLDEN_RED_RESET   = 16'd3741;
   localparam logic [GAIN_W-1:0] GOLDEN_GREEN_RESET = 16'd1940;
   localparam logic [GAIN_W-1:0] GOLDEN_BLUE_RESET  = 16'd2805;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_IN  = 2'd1;
   localparam logic [1:0] ST_ZERO_DIV = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   localparam logic [1:0] BR_SCALE_RB = 2'd0;
   localparam logic [1:0] BR_HOLD_R   = 2'd1;
   localparam logic [1:0] BR_HOLD_B   = 2'd2;

   localparam logic [WORD_W-1:0] UNITY     = 32'h0000_1000;
   localparam logic [WORD_W-1:0] ROUND_ADD = 32'h0000_0008;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic zero_in;
      logic zero_golden;
   } line1_type;

   typedef struct packed {
      logic [1:0] branch;
      logic [1:0] status;
      word_type   mul_op;
      word_type   den3;
   } line2_type;

   typedef struct packed {
      logic [1:0] branch;
      logic [1:0] status;
      word_type   q2;
   } line3_type;
endpackage
`default_nettype wire

// ===== rtl/awbcal_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module awbcal_div
   import awbcal_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire word_type num,
   input  wire word_type den,
   output logic          out_valid,
   output word_type      quo
);
   logic     vld_ff [DIV_STAGES];
   word_type rem_ff [DIV_STAGES];
   word_type nq_ff  [DIV_STAGES];
   word_type den_ff [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic          vld_prev;
      word_type      rem_prev, nq_prev, den_prev;
      logic [WORD_W:0] trial;
      logic          bit_in;
      word_type      rem_in, nq_in;

      if (i == 0) begin : g_first
         assign vld_prev = in_valid;
         assign rem_prev = '0;
         assign nq_prev  = num;
         assign den_prev = den;
      end else begin : g_next
         assign vld_prev = vld_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign nq_prev  = nq_ff[i-1];
         assign den_prev = den_ff[i-1];
      end

      always_comb begin
         trial  = {rem_prev, nq_prev[WORD_W-1]};
         bit_in = (trial >= {1'b0, den_prev});
         if (bit_in) begin
            rem_in = WORD_W'(trial - {1'b0, den_prev});
         end else begin
            rem_in = trial[WORD_W-1:0];
         end
         nq_in = {nq_prev[WORD_W-2:0], bit_in};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
         rem_ff[i] <= rem_in;
         nq_ff[i]  <= nq_in;
         den_ff[i] <= den_prev;
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign quo       = nq_ff[DIV_STAGES-1];
endmodule
`default_nettype wire

// ===== rtl/awb_calibration_gain_calc_top.sv =====
// Top level of the white-balance calibration gain calculator.
//
// Usage: raise start with the three measured module gains on req_module_*.
// An item is transferred at each rising edge where start is high and busy is
// low; busy never rises, so a new item may be transferred in every cycle.
// The golden-module gains are written through csr_we, csr_index and csr_wdata;
// the user must write them only while no item is in flight; the block does not enforce it.
// Each result is shown on the rsp_ ports for one cycle with rsp_valid high.
// The receiver cannot stall, so results are never held back.
// Throughput is one item per cycle. The path runs through three chained levels of
// 32-stage dividers (four in parallel at the first level), one quotient bit per stage,
// plus a product stage, a branch stage, a multiply stage and an output stage.
// Reset clears all valid bits and loads the default golden gains.
`default_nettype none
module awb_calibration_gain_calc_top
   import awbcal_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [GAIN_W-1:0]    req_module_red,
   input  wire logic [GAIN_W-1:0]    req_module_green,
   input  wire logic [GAIN_W-1:0]    req_module_blue,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [DGAIN_W-1:0]        rsp_red_digital_gain,
   output logic [DGAIN_W-1:0]        rsp_green_digital_gain,
   output logic [DGAIN_W-1:0]        rsp_blue_digital_gain,
   output logic                      rsp_write_red,
   output logic                      rsp_write_green,
   output logic                      rsp_write_blue,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]    csr_wdata
);
   logic [GAIN_W-1:0] gold_r_ff, gold_g_ff, gold_b_ff;
   logic              accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         gold_r_ff <= GOLDEN_RED_RESET;
         gold_g_ff <= GOLDEN_GREEN_RESET;
         gold_b_ff <= GOLDEN_BLUE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GOLDEN_RED:   gold_r_ff <= csr_wdata;
            CSR_GOLDEN_GREEN: gold_g_ff <= csr_wdata;
            CSR_GOLDEN_BLUE:  gold_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // First division: module and golden ratios in 16.12.
   word_type  rg, bg, rgt, bgt;
   logic      v1_rg, v1_bg, v1_rgt, v1_bgt;
   line1_type line1_in;
   line1_type line1_ff [DIV_STAGES];

   assign line1_in.zero_in = (req_module_red == '0) || (req_module_green == '0) ||
                             (req_module_blue == '0);
   assign line1_in.zero_golden = (gold_g_ff == '0);

   awbcal_div u_div_rg (.clock, .reset, .in_valid(accept),
      .num({4'd0, req_module_red, 12'd0}), .den({16'd0, req_module_green}),
      .out_valid(v1_rg), .quo(rg));
   awbcal_div u_div_bg (.clock, .reset, .in_valid(accept),
      .num({4'd0, req_module_blue, 12'd0}), .den({16'd0, req_module_green}),
      .out_valid(v1_bg), .quo(bg));
   awbcal_div u_div_rgt (.clock, .reset, .in_valid(accept),
      .num({4'd0, gold_r_ff, 12'd0}), .den({16'd0, gold_g_ff}),
      .out_valid(v1_rgt), .quo(rgt));
   awbcal_div u_div_bgt (.clock, .reset, .in_valid(accept),
      .num({4'd0, gold_b_ff, 12'd0}), .den({16'd0, gold_g_ff}),
      .out_valid(v1_bgt), .quo(bgt));

   always_ff @(posedge clock) begin
      line1_ff[0] <= line1_in;
      for (int i = 1; i < DIV_STAGES; i++) begin
         line1_ff[i] <= line1_ff[i-1];
      end
   end

   // Product stage for the ratio comparison.
   logic      p_valid_ff;
   word_type  p_rg_ff, p_bg_ff, p_rgt_ff, p_bgt_ff, p_prod1_ff, p_prod2_ff;
   line1_type p_line_ff;
   logic [2*WORD_W-1:0] prod1_full, prod2_full;

   assign prod1_full = rg * bgt;
   assign prod2_full = bg * rgt;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= v1_rg && v1_bg && v1_rgt && v1_bgt;
      end
      p_rg_ff    <= rg;
      p_bg_ff    <= bg;
      p_rgt_ff   <= rgt;
      p_bgt_ff   <= bgt;
      p_prod1_ff <= prod1_full[WORD_W-1:0];
      p_prod2_ff <= prod2_full[WORD_W-1:0];
      p_line_ff  <= line1_ff[DIV_STAGES-1];
   end

   // Branch stage: pick the held channel, set the status and set up the second division.
   logic      q_valid_ff;
   word_type  q_num_ff, q_den_ff;
   line2_type q_line_ff;
   word_type  q_num_in, q_den_in;
   line2_type q_line_in;
   logic      den_zero;

   always_comb begin
      if ((p_rg_ff > p_rgt_ff) && (p_bg_ff > p_bgt_ff)) begin
         q_line_in.branch = BR_SCALE_RB;
         q_num_in         = {p_rg_ff[WORD_W-13:0], 12'd0};
         q_den_in         = p_rgt_ff;
         q_line_in.mul_op = p_bg_ff;
         q_line_in.den3   = p_bgt_ff;
         den_zero         = (p_rgt_ff == '0) || (p_bgt_ff == '0);
      end else if (p_prod1_ff < p_prod2_ff) begin
         q_line_in.branch = BR_HOLD_R;
         q_num_in         = {p_rgt_ff[WORD_W-13:0], 12'd0};
         q_den_in         = p_rg_ff;
         q_line_in.mul_op = p_bg_ff;
         q_line_in.den3   = p_bgt_ff;
         den_zero         = (p_rg_ff == '0) || (p_bgt_ff == '0);
      end else begin
         q_line_in.branch = BR_HOLD_B;
         q_num_in         = {p_bgt_ff[WORD_W-13:0], 12'd0};
         q_den_in         = p_bg_ff;
         q_line_in.mul_op = p_rg_ff;
         q_line_in.den3   = p_rgt_ff;
         den_zero         = (p_bg_ff == '0) || (p_rgt_ff == '0);
      end
      priority if (p_line_ff.zero_in) begin
         q_line_in.status = ST_ZERO_IN;
      end else if (p_line_ff.zero_golden || den_zero) begin
         q_line_in.status = ST_ZERO_DIV;
      end else begin
         q_line_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= p_valid_ff;
      end
      q_num_ff  <= q_num_in;
      q_den_ff  <= q_den_in;
      q_line_ff <= q_line_in;
   end

   // Second division.
   word_type  q2;
   logic      v2;
   line2_type line2_ff [DIV_STAGES];

   awbcal_div u_div_second (.clock, .reset, .in_valid(q_valid_ff),
      .num(q_num_ff), .den(q_den_ff), .out_valid(v2), .quo(q2));

   always_ff @(posedge clock) begin
      line2_ff[0] <= q_line_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         line2_ff[i] <= line2_ff[i-1];
      end
   end

   // Multiply stage feeding the third division.
   logic      m_valid_ff;
   word_type  m_prod_ff, m_den_ff;
   line3_type m_line_ff;
   word_type  m_factor;
   logic [2*WORD_W-1:0] m_prod_full;
   line2_type l2;

   assign l2          = line2_ff[DIV_STAGES-1];
   assign m_factor    = (l2.branch == BR_SCALE_RB) ? UNITY : q2;
   assign m_prod_full = m_factor * l2.mul_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= v2;
      end
      m_prod_ff        <= m_prod_full[WORD_W-1:0];
      m_den_ff         <= l2.den3;
      m_line_ff.branch <= l2.branch;
      m_line_ff.status <= l2.status;
      m_line_ff.q2     <= q2;
   end

   // Third division.
   word_type  q3;
   logic      v3;
   line3_type line3_ff [DIV_STAGES];

   awbcal_div u_div_third (.clock, .reset, .in_valid(m_valid_ff),
      .num(m_prod_ff), .den(m_den_ff), .out_valid(v3), .quo(q3));

   always_ff @(posedge clock) begin
      line3_ff[0] <= m_line_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         line3_ff[i] <= line3_ff[i-1];
      end
   end

   // Rounding, range check and output register.
   line3_type l3;
   word_type  r_raw, g_raw, b_raw, r_sum, g_sum, b_sum;
   logic [WORD_W-5:0] r_rnd, g_rnd, b_rnd;
   logic [1:0] status_in;
   logic       ok_in, range_bad;

   assign l3 = line3_ff[DIV_STAGES-1];

   always_comb begin
      unique case (l3.branch)
         BR_SCALE_RB: begin
            r_raw = l3.q2;
            g_raw = UNITY;
            b_raw = q3;
         end
         BR_HOLD_R: begin
            r_raw = UNITY;
            g_raw = l3.q2;
            b_raw = q3;
         end
         default: begin
            r_raw = q3;
            g_raw = l3.q2;
            b_raw = UNITY;
         end
      endcase
      r_sum     = r_raw + ROUND_ADD;
      g_sum     = g_raw + ROUND_ADD;
      b_sum     = b_raw + ROUND_ADD;
      r_rnd     = r_sum[WORD_W-1:4];
      g_rnd     = g_sum[WORD_W-1:4];
      b_rnd     = b_sum[WORD_W-1:4];
      range_bad = (r_rnd[WORD_W-5:DGAIN_W] != '0) || (g_rnd[WORD_W-5:DGAIN_W] != '0) ||
                  (b_rnd[WORD_W-5:DGAIN_W] != '0);
      priority if (l3.status != ST_OK) begin
         status_in = l3.status;
      end else if (range_bad) begin
         status_in = ST_RANGE;
      end else begin
         status_in = ST_OK;
      end
      ok_in = (status_in == ST_OK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= v3;
      end
      rsp_status             <= status_in;
      rsp_red_digital_gain   <= ok_in ? r_rnd[DGAIN_W-1:0] : '0;
      rsp_green_digital_gain <= ok_in ? g_rnd[DGAIN_W-1:0] : '0;
      rsp_blue_digital_gain  <= ok_in ? b_rnd[DGAIN_W-1:0] : '0;
      rsp_write_red          <= ok_in && (r_rnd[DGAIN_W-1:8] != '0);
      rsp_write_green        <= ok_in && (g_rnd[DGAIN_W-1:8] != '0);
      rsp_write_blue         <= ok_in && (b_rnd[DGAIN_W-1:8] != '0);
   end

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("transfer did not produce a result at the expected latency");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_red_digital_gain == '0 && rsp_green_digital_gain == '0 &&
          rsp_blue_digital_gain == '0))
      else $error("error result carries nonzero gains");

   a_write_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_write_red || rsp_write_green || rsp_write_blue)) |->
         rsp_status == ST_OK)
      else $error("write flag set on an error result");
endmodule
`default_nettype wire
